// ===== hdl/twmh_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package twmh_pkg;

    localparam logic [31:0] LANE_INIT0 = 32'hDEADBEEF;
    localparam logic [31:0] LANE_INIT1 = 32'hABCDEF01;
    localparam logic [31:0] LANE_INIT2 = 32'hAA5555AA;
    localparam logic [31:0] LANE_INIT3 = 32'hC0DE9999;
    localparam logic [31:0] MUL_A      = 32'h00002654;
    localparam logic [31:0] MUL_B      = 32'd54435761;
    localparam logic [31:0] GOLDEN     = 32'd2654435761;
    localparam logic [31:0] XOR_PAT    = 32'h8AA8A88A;

    localparam int unsigned ROUNDS      = 8;
    // byte step in every round; even rounds add three cross-lane stages
    localparam int unsigned EVEN_STAGES = 4;
    localparam int unsigned ODD_STAGES  = 1;
    localparam int unsigned LATENCY     = (ROUNDS / 2) * (EVEN_STAGES + ODD_STAGES) + 1;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
    } lanes_t;

    typedef struct packed {
        lanes_t      lanes;
        logic [31:0] prev;
        logic [31:0] nonce;
    } stage_t;

    function automatic logic [31:0] rotl(input logic [31:0] val, input logic [4:0] amt);
        logic [63:0] wide;
        wide = {val, val} << amt;
        return wide[63:32];
    endfunction

endpackage

`default_nettype wire

// ===== hdl/twmh_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module twmh_cell #(
    parameter int unsigned ROUND = 0
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire twmh_pkg::stage_t  in_data,
    output logic                   out_valid,
    output twmh_pkg::stage_t       out_data
);

    localparam int unsigned BYTE_LSB  = 8 * (ROUND % 4);
    localparam logic [4:0]  ROT_LOW   = 5'(ROUND % 4);
    localparam logic [4:0]  ROT_ROUND = 5'(ROUND);
    localparam logic [2:0]  ROUND_BITS = 3'(ROUND);

    logic [31:0]       src;
    logic [7:0]        byte8;
    logic [31:0]       bytew;
    logic [31:0]       prod_a;
    logic [31:0]       prod_b;
    logic [31:0]       prod_g;
    logic [4:0]        rot_b;
    twmh_pkg::stage_t  s1_next;
    twmh_pkg::stage_t  s1_reg;
    logic              v1_reg;

    assign src   = (ROUND < 4) ? in_data.prev : in_data.nonce;
    assign byte8 = src[BYTE_LSB +: 8];
    assign bytew = {24'd0, byte8};
    assign rot_b = {2'd0, byte8[2:0] & ROUND_BITS};

    assign prod_a = bytew * twmh_pkg::MUL_A;
    assign prod_b = bytew * twmh_pkg::MUL_B;
    assign prod_g = bytew * twmh_pkg::GOLDEN;

    always_comb
    begin
        s1_next         = in_data;
        s1_next.lanes.a = (bytew & in_data.lanes.a) ^ twmh_pkg::rotl(bytew, ROT_LOW);
        s1_next.lanes.b = prod_a ^ twmh_pkg::rotl(in_data.lanes.b, rot_b);
        s1_next.lanes.c = in_data.lanes.c ^ prod_b;
        s1_next.lanes.d = prod_g ^ twmh_pkg::rotl(bytew ^ twmh_pkg::XOR_PAT, ROT_ROUND);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg <= s1_next;
    end

    generate
        if (ROUND % 2 == 0)
        begin : g_cross
            twmh_pkg::stage_t  s2_next;
            twmh_pkg::stage_t  s2_reg;
            twmh_pkg::stage_t  s3_next;
            twmh_pkg::stage_t  s3_reg;
            twmh_pkg::stage_t  s4_next;
            twmh_pkg::stage_t  s4_reg;
            logic [31:0]       mul2;
            logic [31:0]       mul3;
            logic              v2_reg;
            logic              v3_reg;
            logic              v4_reg;

            // a = GOLDEN ^ b * (c & d)
            assign mul2 = s1_reg.lanes.b * (s1_reg.lanes.c & s1_reg.lanes.d);
            always_comb
            begin
                s2_next         = s1_reg;
                s2_next.lanes.a = twmh_pkg::GOLDEN ^ mul2;
            end

            // b = a * c ^ rotl(d, b & 0xF), old b still in the stage
            assign mul3 = s2_reg.lanes.a * s2_reg.lanes.c;
            always_comb
            begin
                s3_next         = s2_reg;
                s3_next.lanes.b = mul3 ^ twmh_pkg::rotl(s2_reg.lanes.d,
                                                        {1'b0, s2_reg.lanes.b[3:0]});
            end

            always_comb
            begin
                s4_next         = s3_reg;
                s4_next.lanes.c = twmh_pkg::GOLDEN ^ (s3_reg.lanes.d &
                                  twmh_pkg::rotl(s3_reg.lanes.b, {1'b0, s3_reg.lanes.c[3:0]}));
                s4_next.lanes.d = s3_reg.lanes.d
                                  ^ twmh_pkg::rotl(twmh_pkg::GOLDEN, {1'b0, s4_next.lanes.c[3:0]})
                                  ^ s3_reg.lanes.a;
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    v2_reg <= 1'b0;
                    v3_reg <= 1'b0;
                    v4_reg <= 1'b0;
                end
                else
                begin
                    v2_reg <= v1_reg;
                    v3_reg <= v2_reg;
                    v4_reg <= v3_reg;
                end
            end

            always_ff @(posedge clk)
            begin
                s2_reg <= s2_next;
                s3_reg <= s3_next;
                s4_reg <= s4_next;
            end

            assign out_valid = v4_reg;
            assign out_data  = s4_reg;
        end
        else
        begin : g_plain
            assign out_valid = v1_reg;
            assign out_data  = s1_reg;
        end
    endgenerate

endmodule

`default_nettype wire

// ===== hdl/two_word_mixing_hash.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Two-word mixing hash, fully pipelined.
// Input: drive previous_hash and nonce_value with start high; a transfer
// happens at every rising edge where start is high and busy is low. busy
// is always low, so a new item can be taken in every cycle.
// Output: hash_out is valid for exactly one cycle, flagged by done, in the
// same order as the inputs went in. The receiver cannot stall the block.
// Throughput is one item per cycle.
// The datapath is a row of eight round cells, one per input byte. Odd
// rounds take one stage (byte mixing); even rounds take four stages (byte
// mixing, two dependent 32x32 multiplies, then the rotate/XOR tail). A last
// register XORs the four lanes. Latency is set by those four even-round
// multiply chains.
// Reset clears all valid flags; items in flight are dropped and no result
// is flagged until a new item has gone through the whole chain.

module two_word_mixing_hash (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [31:0] previous_hash,
    input  wire logic [31:0] nonce_value,
    output logic             done,
    output logic [31:0]      hash_out
);

    logic              link_valid [twmh_pkg::ROUNDS + 1];
    twmh_pkg::stage_t  link_data  [twmh_pkg::ROUNDS + 1];
    logic              done_reg;
    logic [31:0]       hash_reg;
    logic [31:0]       hash_next;

    assign busy = 1'b0;

    assign link_valid[0]          = start & ~busy;
    assign link_data[0].lanes.a   = twmh_pkg::LANE_INIT0;
    assign link_data[0].lanes.b   = twmh_pkg::LANE_INIT1;
    assign link_data[0].lanes.c   = twmh_pkg::LANE_INIT2;
    assign link_data[0].lanes.d   = twmh_pkg::LANE_INIT3;
    assign link_data[0].prev      = previous_hash;
    assign link_data[0].nonce     = nonce_value;

    generate
        for (genvar r = 0; r < twmh_pkg::ROUNDS; r++)
        begin : g_round
            twmh_cell #(
                .ROUND (r)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .in_valid  (link_valid[r]),
                .in_data   (link_data[r]),
                .out_valid (link_valid[r + 1]),
                .out_data  (link_data[r + 1])
            );
        end
    endgenerate

    assign hash_next = link_data[twmh_pkg::ROUNDS].lanes.a ^ link_data[twmh_pkg::ROUNDS].lanes.b
                     ^ link_data[twmh_pkg::ROUNDS].lanes.c ^ link_data[twmh_pkg::ROUNDS].lanes.d;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= link_valid[twmh_pkg::ROUNDS];
        end
    end

    always_ff @(posedge clk)
    begin
        hash_reg <= hash_next;
    end

    assign done     = done_reg;
    assign hash_out = hash_reg;

`ifndef SYNTHESIS
    // every transfer comes out as a done result once it has passed the whole chain
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##(twmh_pkg::LATENCY) done)
        else $error("result missing after input transfer");

    // no result without a matching transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, twmh_pkg::LATENCY))
        else $error("result without input transfer");

    // equal inputs in back-to-back transfers hash to equal results
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && $past(rst_n) && $past(start && !busy)
         && previous_hash == $past(previous_hash) && nonce_value == $past(nonce_value))
        |-> ##(twmh_pkg::LATENCY) (done && hash_out == $past(hash_out)))
        else $error("hash differs for repeated input");
`endif

endmodule

`default_nettype wire
